// ===== design/rcc_pkg.sv =====
// Shared types and constants for the RGB 3x3 convolution block.
// Used by the channel interfaces, the lanes, the output queue and the top level.
package rcc_pkg;

  localparam int KERNEL_MAX     = 3;
  localparam int COEF_FRAC_BITS = 12;
  localparam int NUM_CH         = 3;
  localparam int NUM_TAPS       = 9;
  localparam int PIX_W          = 8;
  localparam int COEF_W         = 16;
  localparam int PROD_W         = 25;
  localparam int SUM_W          = 29;
  localparam int CFG_W          = 48;
  localparam int CFG_IDX_W      = 3;
  localparam int HEIGHT_W       = 13;
  localparam int WIDTH_REG_W    = 11;
  localparam int PIX_MAX        = 255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MID     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM  = 3'd5;

  // Input item kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef logic [PIX_W-1:0]         samp_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    samp_t out_red;
    samp_t out_green;
    samp_t out_blue;
    logic  frame_last;
  } result_t;

  // Per-item control that travels along the pipeline
  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } tag_t;

endpackage

// ===== design/rcc_stream_if.sv =====
// Valid/ready channel interfaces for pixel input and filtered output.
// Depends on rcc_pkg for the sample type.
interface rcc_in_if;
  import rcc_pkg::*;
  logic  valid;
  logic  ready;
  logic  req_type;
  samp_t in_red;
  samp_t in_green;
  samp_t in_blue;
  modport source (output valid, req_type, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, req_type, in_red, in_green, in_blue, output ready);
endinterface

interface rcc_out_if;
  import rcc_pkg::*;
  logic  valid;
  logic  ready;
  samp_t out_red;
  samp_t out_green;
  samp_t out_blue;
  logic  frame_last;
  modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

// ===== design/rcc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rcc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rcc_lane.sv =====
// One color channel of the convolution: nine tap products, row sums, clamp.
// Depends on rcc_pkg; the products, the row sums and the result are each registered.
module rcc_lane (
  input  logic                   clk,
  input  rcc_pkg::samp_t         pix  [rcc_pkg::NUM_TAPS],
  input  logic [rcc_pkg::NUM_TAPS-1:0] mask,
  input  rcc_pkg::coef_t         coef [rcc_pkg::NUM_TAPS],
  output rcc_pkg::samp_t         res
);
  import rcc_pkg::*;

  logic signed [PROD_W-1:0] prod [NUM_TAPS];
  logic signed [SUM_W-1:0]  row_sum [3];
  logic signed [SUM_W-1:0]  total;
  logic signed [SUM_W-1:0]  shifted;

  // Multiply each tap, drop taps that fall outside the frame
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      if (mask[i]) begin
        prod[i] <= $signed({1'b0, pix[i]}) * coef[i];
      end else begin
        prod[i] <= '0;
      end
    end
  end

  // Sum each kernel row
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] <= SUM_W'(prod[3*r]) + SUM_W'(prod[3*r+1]) + SUM_W'(prod[3*r+2]);
    end
  end

  // Final sum, clamp at zero, drop fraction, clamp at full scale
  always_comb begin
    total   = row_sum[0] + row_sum[1] + row_sum[2];
    shifted = total >>> COEF_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (total < 0) begin
      res <= '0;
    end else if (shifted > SUM_W'(PIX_MAX)) begin
      res <= PIX_W'(PIX_MAX);
    end else begin
      res <= shifted[PIX_W-1:0];
    end
  end

endmodule

// ===== design/rcc_merge.sv =====
// Merge stage: joins the three lane results and the frame tag into one
// result item and queues it for the output channel. Depends on rcc_pkg.
module rcc_merge #(
  parameter int DEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  rcc_pkg::samp_t              lane_res [rcc_pkg::NUM_CH],
  input  logic                        last,
  output logic [$clog2(DEPTH+1)-1:0]  count,
  rcc_out_if.source                   pix_out
);
  import rcc_pkg::*;

  localparam int PW = $clog2(DEPTH);

  result_t         queue [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic            pop;
  result_t         entry;

  assign pop = pix_out.valid && pix_out.ready;

  always_comb begin
    entry.out_red    = lane_res[0];
    entry.out_green  = lane_res[1];
    entry.out_blue   = lane_res[2];
    entry.frame_last = last;
  end

  // Store merged results
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign pix_out.valid      = (count != '0);
  assign pix_out.out_red    = queue[rd_ptr].out_red;
  assign pix_out.out_green  = queue[rd_ptr].out_green;
  assign pix_out.out_blue   = queue[rd_ptr].out_blue;
  assign pix_out.frame_last = queue[rd_ptr].frame_last;

endmodule

// ===== design/rgb_convolution_clamp.sv =====
// RGB 3x3 zero-padded convolution with clamp, one pixel per cycle sustained
// while not busy and the output queue has room. A result passes line store read,
// window, multiply, row sum and clamp registers to the output queue; it lags the
// frame by (W+1) items for a 3-tap kernel, so flush items drain the last row. A
// config write makes the block busy while it rebuilds frame size and output
// position. Sync reset clears counters and the output queue; the line stores
// are not cleared.
module rgb_convolution_clamp #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  rcc_in_if.sink                         pix_in,
  rcc_out_if.source                      pix_out,
  input  logic                           cfg_we,
  input  logic [rcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcc_pkg::CFG_W-1:0]      cfg_data
);
  import rcc_pkg::*;

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int IW     = $clog2(MAX_WIDTH * 8191 + 1);
  localparam int CW     = $clog2(IW + 3);
  localparam int QDEPTH = 8;
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Configuration registers
  logic [WIDTH_REG_W-1:0] image_width;
  logic [HEIGHT_W-1:0]    image_height;
  logic [1:0]             kernel_size;
  logic [CFG_W-1:0]       coef_rows [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_REG_W'(1024);
      image_height <= HEIGHT_W'(1024);
      kernel_size  <= 2'd3;
      coef_rows[0] <= '0;
      coef_rows[1] <= CFG_W'(48'h0000_1000_0000);
      coef_rows[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        REG_KERNEL_SIZE:  kernel_size  <= cfg_data[1:0];
        REG_COEF_TOP:     coef_rows[0] <= cfg_data;
        REG_COEF_MID:     coef_rows[1] <= cfg_data;
        REG_COEF_BOTTOM:  coef_rows[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective frame and kernel sizes, registered
  logic [WW-1:0]       w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [1:0]          s_eff;
  logic [IW-1:0]       total;
  logic                f3;

  always_ff @(posedge clk) begin
    if (image_width == '0) begin
      w_eff <= WW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff <= WW'(MAX_WIDTH);
    end else begin
      w_eff <= WW'(image_width);
    end
    h_eff <= (image_height == '0) ? HEIGHT_W'(1) : image_height;
    if (kernel_size == 2'd0) begin
      s_eff <= 2'd1;
    end else if (32'(kernel_size) > 32'(KERNEL_MAX)) begin
      s_eff <= 2'(KERNEL_MAX);
    end else begin
      s_eff <= kernel_size;
    end
    total <= IW'(w_eff * h_eff);
  end

  assign f3 = (s_eff == 2'd3);

  // Align kernel taps to the right/bottom of the 3x3 window
  coef_t coefa [NUM_TAPS];

  for (genvar a = 0; a < 3; a++) begin : g_ca
    for (genvar b = 0; b < 3; b++) begin : g_cb
      always_ff @(posedge clk) begin
        unique case (s_eff)
          2'd3: coefa[a*3+b] <= coef_t'(coef_rows[a][16*b +: 16]);
          2'd2: begin
            if (a >= 1 && b >= 1) begin
              coefa[a*3+b] <= coef_t'(coef_rows[(a >= 1) ? a-1 : 0][16*((b >= 1) ? b-1 : 0) +: 16]);
            end else begin
              coefa[a*3+b] <= '0;
            end
          end
          default: begin
            if (a == 2 && b == 2) begin
              coefa[a*3+b] <= coef_t'(coef_rows[0][15:0]);
            end else begin
              coefa[a*3+b] <= '0;
            end
          end
        endcase
      end
    end
  end

  // Busy window after a config write; divider rebuilds output row/column
  logic [CW-1:0]  busy_cnt;
  logic           busy;
  logic [IW-1:0]  div_q;
  logic [WW-1:0]  div_r;
  logic [WW:0]    div_trial;
  logic           div_ge;
  logic [WW-1:0]  div_r_next;
  logic [IW-1:0]  div_q_next;

  assign busy = (busy_cnt != '0);

  always_comb begin
    div_trial  = {div_r, div_q[IW-1]};
    div_ge     = (div_trial >= {1'b0, w_eff});
    div_r_next = div_ge ? WW'(div_trial - {1'b0, w_eff}) : div_trial[WW-1:0];
    div_q_next = {div_q[IW-2:0], div_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_cnt <= '0;
    end else if (cfg_we) begin
      busy_cnt <= CW'(IW + 2);
    end else if (busy) begin
      busy_cnt <= busy_cnt - 1'b1;
    end
  end

  // Input position and output index counters
  logic [WW-1:0]       in_col;
  logic [1:0]          in_row;
  logic [IW-1:0]       out_idx;
  logic [HEIGHT_W-1:0] oi;
  logic [WW-1:0]       oj;

  always_ff @(posedge clk) begin
    if (busy_cnt == CW'(IW + 1)) begin
      div_q <= out_idx;
      div_r <= '0;
    end else if (busy) begin
      div_q <= div_q_next;
      div_r <= div_r_next;
    end
  end

  // Stage 0: position of the transferred item
  logic          accept;
  logic          col_wrap;
  logic [WW-1:0] col0;
  logic [1:0]    row_n;
  logic          early;
  logic          emit;
  logic          last;
  logic [23:0]   cur;
  logic [2:0]    rowok;
  logic [2:0]    colok;
  logic [NUM_TAPS-1:0] mask0;

  assign accept = pix_in.valid && pix_in.ready;

  always_comb begin
    col_wrap = (in_col >= w_eff);
    col0     = col_wrap ? '0 : in_col;
    if (col_wrap) begin
      row_n = (in_row == 2'd2) ? 2'd2 : in_row + 2'd1;
    end else begin
      row_n = in_row;
    end
    early = f3 && ((row_n == 2'd0) || ((row_n == 2'd1) && (col0 == '0)));
    emit  = !early && (out_idx < total);
    last  = emit && ((IW + 1)'(out_idx) + 1'b1 >= (IW + 1)'(total));
    cur   = (pix_in.req_type == REQ_FLUSH) ? '0 :
            {pix_in.in_blue, pix_in.in_green, pix_in.in_red};
    rowok[0] = f3 && (oi != '0);
    rowok[1] = f3 || (oi != '0);
    rowok[2] = !f3 || (oi != h_eff - 1'b1);
    colok[0] = f3 && (oj != '0);
    colok[1] = f3 || (oj != '0);
    colok[2] = !f3 || (oj != w_eff - 1'b1);
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        mask0[a*3+b] = rowok[a] && colok[b];
      end
    end
  end

  // Advance counters on transfer; reload output position after divide
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_idx <= '0;
      oi      <= '0;
      oj      <= '0;
    end else if (busy_cnt == CW'(1)) begin
      oi <= div_q_next[HEIGHT_W-1:0];
      oj <= div_r_next;
    end else if (accept) begin
      if (last) begin
        in_col  <= '0;
        in_row  <= '0;
        out_idx <= '0;
        oi      <= '0;
        oj      <= '0;
      end else begin
        in_col <= col0 + 1'b1;
        in_row <= row_n;
        if (emit) begin
          out_idx <= out_idx + 1'b1;
          if (oj == w_eff - 1'b1) begin
            oj <= '0;
            oi <= oi + 1'b1;
          end else begin
            oj <= oj + 1'b1;
          end
        end
      end
    end
  end

  // Stage 1: line store read data, window shift
  tag_t                st1_tag;
  logic [AW-1:0]       st1_addr;
  logic [23:0]         st1_cur;
  logic [NUM_TAPS-1:0] st1_mask;
  logic [47:0]         ram_rdata;
  logic [47:0]         ram_wdata;
  logic [47:0]         lines;
  logic                fwd;
  logic [47:0]         fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_tag <= '0;
    end else begin
      st1_tag.valid <= accept;
      st1_tag.emit  <= accept && emit;
      st1_tag.last  <= accept && last;
    end
  end

  always_ff @(posedge clk) begin
    st1_addr <= col0[AW-1:0];
    st1_cur  <= cur;
    st1_mask <= mask0;
    fwd      <= st1_tag.valid && accept && (st1_addr == col0[AW-1:0]);
    fwd_data <= ram_wdata;
  end

  assign lines     = fwd ? fwd_data : ram_rdata;
  assign ram_wdata = {lines[23:0], st1_cur};

  rcc_ram #(
    .WIDTH (48),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (st1_tag.valid),
    .waddr (st1_addr),
    .wdata (ram_wdata),
    .raddr (col0[AW-1:0]),
    .rdata (ram_rdata)
  );

  logic [23:0] window [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          window[a][b] <= '0;
        end
      end
    end else if (st1_tag.valid) begin
      for (int a = 0; a < 3; a++) begin
        window[a][0] <= window[a][1];
        window[a][1] <= window[a][2];
      end
      window[0][2] <= lines[47:24];
      window[1][2] <= lines[23:0];
      window[2][2] <= st1_cur;
    end
  end

  // Stage 2 and beyond: tags follow the lanes
  tag_t                s2_tag;
  tag_t                p3_tag;
  tag_t                p4_tag;
  tag_t                p5_tag;
  logic [NUM_TAPS-1:0] s2_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag <= '0;
      p3_tag <= '0;
      p4_tag <= '0;
      p5_tag <= '0;
    end else begin
      s2_tag <= st1_tag;
      p3_tag <= s2_tag;
      p4_tag <= p3_tag;
      p5_tag <= p4_tag;
    end
  end

  always_ff @(posedge clk) begin
    s2_mask <= st1_mask;
  end

  // Channel lanes
  samp_t lane_pix [NUM_CH][NUM_TAPS];
  samp_t lane_res [NUM_CH];

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          lane_pix[ch][a*3+b] = window[a][b][8*ch +: 8];
        end
      end
    end
  end

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    rcc_lane u_lane (
      .clk  (clk),
      .pix  (lane_pix[ch]),
      .mask (s2_mask),
      .coef (coefa),
      .res  (lane_res[ch])
    );
  end

  // Merge and queue; hold input while the queue could overflow
  logic [QCW-1:0] q_count;
  logic [2:0]     inflight;

  assign inflight = 3'(st1_tag.emit) + 3'(s2_tag.emit) + 3'(p3_tag.emit) +
                    3'(p4_tag.emit) + 3'(p5_tag.emit);

  assign pix_in.ready = !busy &&
                        (((QCW + 1)'(q_count) + (QCW + 1)'(inflight)) < (QCW + 1)'(QDEPTH));

  rcc_merge #(
    .DEPTH (QDEPTH)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .push     (p5_tag.emit),
    .lane_res (lane_res),
    .last     (p5_tag.last),
    .count    (q_count),
    .pix_out  (pix_out)
  );

endmodule

// ===== design/rcc_checker.sv =====
// Port-level checks for the RGB convolution block, bound to its top level.
// Depends on rcc_pkg for the result layout.
module rcc_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input rcc_pkg::result_t out_item,
  input logic             cfg_we
);
  import rcc_pkg::*;

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Queue is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // A config write blocks input while the position is rebuilt
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("input taken right after config write");

endmodule

bind rgb_convolution_clamp rcc_checker u_rcc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .out_item  ({pix_out.out_red, pix_out.out_green, pix_out.out_blue, pix_out.frame_last}),
  .cfg_we    (cfg_we)
);

// ===== tb/rgb_convolution_clamp_test.sv =====
// Self-checking test for rgb_convolution_clamp: frames in raster order through valid/ready
// channels, results checked against a cycle-free predictor of the filter.
// Depends on rcc_pkg, rcc_stream_if.sv and the design files.
module rgb_convolution_clamp_test;
  import rcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX   = 1024;
  localparam int IDLE_LIMIT = 5000;
  localparam int PAUSE_CYC  = 40;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  rcc_in_if  pix_in_ch ();
  rcc_out_if pix_out_ch ();

  rgb_convolution_clamp dut (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_in_ch),
    .pix_out   (pix_out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow configuration and filter state
  logic [10:0]     img_w;
  logic [12:0]     img_h;
  logic [1:0]      kern_size;
  logic [47:0]     coef_rows [3];
  logic [23:0]     row_upper [LINE_MAX];
  logic [23:0]     row_lower [LINE_MAX];
  logic [23:0]     window [3][3];
  int unsigned     col_ctr, row_ctr, out_ctr;

  result_t         expected_pixels [$];
  int              send_idle_pct, recv_idle_pct;
  int              hold_left;
  int              error_count, items_sent, results_seen, frames_sent;

  // Clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int unsigned eff_width();
    if (img_w == 0) return 1;
    if (img_w > LINE_MAX) return LINE_MAX;
    return img_w;
  endfunction

  function automatic int unsigned eff_height();
    return (img_h == 0) ? 1 : img_h;
  endfunction

  function automatic int unsigned eff_kernel();
    return (kern_size == 0) ? 1 : kern_size;
  endfunction

  // Advance the filter by one item; return 1 when it yields a filtered pixel
  function automatic bit filter_pixel(input logic req, input samp_t r, g, b,
                                      output result_t res);
    int unsigned w, hgt, s, hf, lag, total, c, oi, oj;
    longint      pos, rr, cc, acc, q;
    logic [23:0] cur, up, lo;
    coef_t       cf;
    samp_t       vals [3];
    int unsigned px;
    w     = eff_width();
    hgt   = eff_height();
    s     = eff_kernel();
    hf    = s / 2;
    lag   = (s - 1 - hf) * (w + 1);
    total = w * hgt;
    res   = '0;
    if (col_ctr >= w) begin
      col_ctr = 0;
      row_ctr++;
    end
    cur = (req == REQ_PIXEL) ? {b, g, r} : 24'd0;
    c = col_ctr;
    up = row_upper[c];
    lo = row_lower[c];
    row_upper[c] = lo;
    row_lower[c] = cur;
    for (int k = 0; k < 3; k++) begin
      window[k][0] = window[k][1];
      window[k][1] = window[k][2];
    end
    window[0][2] = up;
    window[1][2] = lo;
    window[2][2] = cur;
    pos = longint'(row_ctr) * w + col_ctr;
    col_ctr++;
    if (pos < lag || out_ctr >= total) return 1'b0;
    oi = out_ctr / w;
    oj = out_ctr % w;
    for (int ch = 0; ch < 3; ch++) begin
      acc = 0;
      for (int k = 0; k < s; k++) begin
        rr = longint'(oi) + k - hf;
        if (rr < 0 || rr >= hgt) continue;
        for (int t = 0; t < s; t++) begin
          cc = longint'(oj) + t - hf;
          if (cc < 0 || cc >= w) continue;
          px = (window[3-s+k][3-s+t] >> (8 * ch)) & 8'hFF;
          cf = coef_rows[k][16*t +: 16];
          acc += longint'(px) * longint'(cf);
        end
      end
      if (acc < 0) vals[ch] = 8'd0;
      else begin
        q = acc >>> COEF_FRAC_BITS;
        vals[ch] = (q > PIX_MAX) ? 8'(PIX_MAX) : 8'(q);
      end
    end
    res.out_red   = vals[0];
    res.out_green = vals[1];
    res.out_blue  = vals[2];
    if (out_ctr + 1 >= total) begin
      res.frame_last = 1'b1;
      out_ctr = 0;
      col_ctr = 0;
      row_ctr = 0;
    end else begin
      res.frame_last = 1'b0;
      out_ctr++;
    end
    return 1'b1;
  endfunction

  // Offer one item, hold it until transfer, then predict its result
  task automatic send_item(input logic req, input samp_t r, g, b);
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in_ch.valid    <= 1'b1;
    pix_in_ch.req_type <= req;
    pix_in_ch.in_red   <= r;
    pix_in_ch.in_green <= g;
    pix_in_ch.in_blue  <= b;
    do @(posedge clk); while (!pix_in_ch.ready);
    items_sent++;
    if (filter_pixel(req, r, g, b, res)) expected_pixels.push_back(res);
  endtask

  // Drain outstanding results, wait out the block, then write all registers
  task automatic configure(input logic [10:0] w, input logic [12:0] h, input logic [1:0] k,
                           input logic [47:0] top, mid, bottom);
    logic [47:0] vals [6];
    pix_in_ch.valid <= 1'b0;
    wait (expected_pixels.size() == 0);
    repeat (PAUSE_CYC) @(posedge clk);
    vals = '{48'(w), 48'(h), 48'(k), top, mid, bottom};
    foreach (vals[i]) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    img_w = w;
    img_h = h;
    kern_size = k;
    coef_rows[0] = top;
    coef_rows[1] = mid;
    coef_rows[2] = bottom;
  endtask

  function automatic samp_t rand_samp();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Three taps: small signed, full random, extremes or small positive
  function automatic logic [47:0] rand_coef_row();
    logic [47:0] row;
    for (int t = 0; t < 3; t++)
      case ($urandom_range(3))
        0: row[16*t +: 16] = 16'($urandom_range(16'h1000) - 16'h0800);
        1: row[16*t +: 16] = 16'($urandom);
        2: row[16*t +: 16] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        default: row[16*t +: 16] = 16'($urandom_range(16'h0600));
      endcase
    return row;
  endfunction

  // Send one frame plus its drain; stray flushes and drain pixels mixed in
  task automatic send_frame(input int flush_pct, input int drain_pix_pct);
    int unsigned w, s, total, lag;
    w     = eff_width();
    s     = eff_kernel();
    total = w * eff_height();
    lag   = (s - 1 - s / 2) * (w + 1);
    for (int unsigned i = 0; i < total + lag; i++) begin
      if (i < total && $urandom_range(99) >= flush_pct)
        send_item(REQ_PIXEL, rand_samp(), rand_samp(), rand_samp());
      else if (i >= total && $urandom_range(99) < drain_pix_pct)
        send_item(REQ_PIXEL, rand_samp(), rand_samp(), rand_samp());
      else
        send_item(REQ_FLUSH, rand_samp(), rand_samp(), rand_samp());
    end
    frames_sent++;
  endtask

  task automatic test_directed();
    // identity kernel, tiny frame with extreme samples
    configure(11'd3, 13'd2, 2'd3, 48'h0, 48'h0000_1000_0000, 48'h0);
    send_item(REQ_PIXEL, 8'd0, 8'd255, 8'd0);
    send_item(REQ_PIXEL, 8'd255, 8'd0, 8'd255);
    send_item(REQ_FLUSH, 8'd0, 8'd0, 8'd0);
    send_item(REQ_PIXEL, 8'd255, 8'd255, 8'd255);
    send_item(REQ_PIXEL, 8'd1, 8'd128, 8'd254);
    send_item(REQ_PIXEL, 8'd255, 8'd255, 8'd255);
    for (int i = 0; i < 3; i++) send_item(REQ_FLUSH, 8'd0, 8'd0, 8'd0);
    send_item(REQ_PIXEL, 8'd7, 8'd7, 8'd7);   // drain slot fed a pixel
    // all taps at largest positive, then largest negative
    configure(11'd2, 13'd2, 2'd3, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    send_frame(0, 0);
    configure(11'd2, 13'd2, 2'd3, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    send_frame(0, 0);
    // zero width and height, zero kernel size, two-tap kernel
    configure(11'd0, 13'd0, 2'd0, rand_coef_row(), rand_coef_row(), rand_coef_row());
    send_frame(0, 0);
    configure(11'd3, 13'd2, 2'd2, rand_coef_row(), rand_coef_row(), rand_coef_row());
    send_frame(20, 50);
    // extra flushes open the next frame
    send_frame(100, 0);
  endtask

  task automatic test_extremes();
    // width above the line limit saturates, single row
    configure(11'd2047, 13'd1, 2'd1, rand_coef_row(), rand_coef_row(), rand_coef_row());
    send_frame(2, 5);
    configure(11'd1, 13'd16, 2'd2, rand_coef_row(), rand_coef_row(), rand_coef_row());
    send_frame(2, 5);
    configure(11'd4, 13'd2, 2'd1, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
              48'hFFFF_FFFF_FFFF);
    send_frame(0, 0);
  endtask

  task automatic test_random_frames(input int item_goal);
    int start;
    start = items_sent;
    while (items_sent - start < item_goal) begin
      configure(11'($urandom_range(12, 1)), 13'($urandom_range(8, 1)),
                2'($urandom_range(3)), rand_coef_row(), rand_coef_row(), rand_coef_row());
      repeat ($urandom_range(3, 1)) send_frame($urandom_range(1) ? 0 : 10, 15);
    end
  endtask

  task automatic test_backpressure();
    configure(11'd6, 13'd4, 2'd3, rand_coef_row(), rand_coef_row(), rand_coef_row());
    hold_left = 400;
    send_frame(0, 0);
    // sender pauses until every result is back
    pix_in_ch.valid <= 1'b0;
    wait (expected_pixels.size() == 0);
    @(posedge clk);
    send_frame(5, 10);
  endtask

  // Receiver: random stalls, or a long hold when requested
  always @(posedge clk) begin
    if (rst) begin
      pix_out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      pix_out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      pix_out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    result_t exp_px;
    if (!rst && pix_out_ch.valid && pix_out_ch.ready) begin
      results_seen++;
      if (expected_pixels.size() == 0) begin
        report_mismatch("result transfer with no prediction pending");
      end else begin
        exp_px = expected_pixels.pop_front();
        if (pix_out_ch.out_red !== exp_px.out_red)
          report_mismatch($sformatf("out_red %0h, predicted %0h",
                                    pix_out_ch.out_red, exp_px.out_red));
        if (pix_out_ch.out_green !== exp_px.out_green)
          report_mismatch($sformatf("out_green %0h, predicted %0h",
                                    pix_out_ch.out_green, exp_px.out_green));
        if (pix_out_ch.out_blue !== exp_px.out_blue)
          report_mismatch($sformatf("out_blue %0h, predicted %0h",
                                    pix_out_ch.out_blue, exp_px.out_blue));
        if (pix_out_ch.frame_last !== exp_px.frame_last)
          report_mismatch($sformatf("frame_last %0b, predicted %0b",
                                    pix_out_ch.frame_last, exp_px.frame_last));
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (pix_in_ch.valid && pix_in_ch.ready) ||
        (pix_out_ch.valid && pix_out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_in_ch.valid = 1'b0;
    pix_in_ch.req_type = REQ_PIXEL;
    pix_in_ch.in_red = '0;
    pix_in_ch.in_green = '0;
    pix_in_ch.in_blue = '0;
    hold_left = 0;
    error_count = 0;
    items_sent = 0;
    results_seen = 0;
    frames_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // reset values of the shadow state
    img_w = 11'd1024;
    img_h = 13'd1024;
    kern_size = 2'd3;
    coef_rows[0] = 48'h0;
    coef_rows[1] = 48'd268435456;
    coef_rows[2] = 48'h0;
    for (int i = 0; i < LINE_MAX; i++) begin
      row_upper[i] = '0;
      row_lower[i] = '0;
    end
    window = '{default: '0};
    col_ctr = 0;
    row_ctr = 0;
    out_ctr = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 15;
    recv_idle_pct = 48;
    test_directed();
    test_extremes();
    test_random_frames(40);
    send_idle_pct = 48;
    recv_idle_pct = 15;
    test_random_frames(40);
    test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(40);

    // Drain and settle
    pix_in_ch.valid <= 1'b0;
    wait (expected_pixels.size() == 0);
    repeat (50) @(posedge clk);
    $display("Covered %0d frames, %0d items in, %0d filtered pixels out, kernel 0..3,",
             frames_sent, items_sent, results_seen);
    $display("widths up to saturation, zero sizes, stalls on both sides.");
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
